[sv/qmm_pkg.sv]
// Package of types, constants and register codes shared by the motor mixer files.
`default_nettype none

package qmm_pkg;

    // Number of non-bypass words that make up one averaging window (1 to 16).
    localparam int AVG_WINDOW = 10;

    // Widths fixed by the word formats.
    localparam int DRIVE_W = 16;
    localparam int SUM_W   = 20;
    localparam int AVG_W   = 20;
    localparam int CNT_W   = 4;
    localparam int MIX_W   = 19;

    // Division of sum * 16 by the window through a reciprocal multiply.
    // With the scaled sum below 2^24 and the rounding error below the window,
    // a shift of 28 makes the truncated quotient exact.
    localparam int DIV_SHIFT = 28;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((64'd1 << DIV_SHIFT) + 64'(AVG_WINDOW) - 64'd1) / RECIP_W'(AVG_WINDOW);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_X_FORMATION     = 3'd0,
        REG_OVERRIDE_ENABLE = 3'd1,
        REG_OVERRIDE_M1     = 3'd2,
        REG_OVERRIDE_M2     = 3'd3,
        REG_OVERRIDE_M3     = 3'd4,
        REG_OVERRIDE_M4     = 3'd5,
        REG_IDLE_FLOOR      = 3'd6
    } reg_idx_t;

    typedef logic [3:0][DRIVE_W-1:0] drive_arr_t;
    typedef logic [3:0][SUM_W-1:0]   sum_arr_t;
    typedef logic [3:0][AVG_W-1:0]   avg_arr_t;

    // Configuration register set.
    typedef struct packed {
        logic       x_formation;
        logic       override_enable;
        drive_arr_t override_m;
        logic [DRIVE_W-1:0] idle_floor;
    } cfg_t;

    // One control command, laid out as on s_axis_tdata with thrust in the lowest bits.
    typedef struct packed {
        logic [15:0] yaw_cmd;
        logic [15:0] pitch_cmd;
        logic [15:0] roll_cmd;
        logic [15:0] thrust_cmd;
    } cmd_t;

endpackage

`default_nettype wire

[sv/qmm_mixer.sv]
// Combinational motor mixer: plus or X mixing, clamp, idle floor and override.
`default_nettype none

module qmm_mixer (
    input  var qmm_pkg::cmd_t       cmd,
    input  var qmm_pkg::cfg_t       cfg,
    output var qmm_pkg::drive_arr_t drive
);
    import qmm_pkg::*;

    logic signed [MIX_W-1:0] t_s;
    logic signed [MIX_W-1:0] r_s;
    logic signed [MIX_W-1:0] p_s;
    logic signed [MIX_W-1:0] y_s;
    logic signed [MIX_W-1:0] r_h;
    logic signed [MIX_W-1:0] p_h;
    logic signed [MIX_W-1:0] mix [4];
    logic [DRIVE_W-1:0] clamped [4];
    logic [DRIVE_W-1:0] floored [4];

    // Extend the commands; halve roll and pitch toward zero for X formation.
    always_comb
    begin
        t_s = {3'b000, cmd.thrust_cmd};
        r_s = {{3{cmd.roll_cmd[15]}}, cmd.roll_cmd};
        p_s = {{3{cmd.pitch_cmd[15]}}, cmd.pitch_cmd};
        y_s = {{3{cmd.yaw_cmd[15]}}, cmd.yaw_cmd};
        r_h = $signed(r_s + MIX_W'(cmd.roll_cmd[15])) >>> 1;
        p_h = $signed(p_s + MIX_W'(cmd.pitch_cmd[15])) >>> 1;
    end

    // Mixing matrix for the two formations.
    always_comb
    begin
        if (cfg.x_formation)
        begin
            mix[0] = t_s - r_h + p_h + y_s;
            mix[1] = t_s - r_h - p_h - y_s;
            mix[2] = t_s + r_h - p_h + y_s;
            mix[3] = t_s + r_h + p_h - y_s;
        end
        else
        begin
            mix[0] = t_s + p_s + y_s;
            mix[1] = t_s - r_s - y_s;
            mix[2] = t_s - p_s + y_s;
            mix[3] = t_s + r_s - y_s;
        end
    end

    // Clamp to the drive range, raise to the idle floor, or take the override.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (mix[i][MIX_W-1])
                clamped[i] = '0;
            else if (mix[i][MIX_W-2:DRIVE_W] != '0)
                clamped[i] = '1;
            else
                clamped[i] = mix[i][DRIVE_W-1:0];

            floored[i] = (clamped[i] < cfg.idle_floor) ? cfg.idle_floor : clamped[i];
            drive[i]   = cfg.override_enable ? cfg.override_m[i] : floored[i];
        end
    end

endmodule

`default_nettype wire

[sv/quad_motor_mixer_with_averager_top.sv]
// Top level of the quadrotor motor mixer with windowed drive averager.
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         s_axis_tvalid/tready      command word; tuser = bypass
//   m_axis    out        m_axis_tvalid/tready      four drives and four averages
//   cfg       in         cfg_valid/cfg_ready       register index and write data
//
// One word is accepted every cycle while m_axis does not stall; a result reaches m_axis
// through the input register, the mix and accumulate register and the output register.
// The divide by the window is one reciprocal multiply in front of the output register.
// A bypass word is taken and dropped at once, producing no result.
// A stall on m_axis fills the three stages before s_axis_tready falls.
// Reset clears the valid flags, the window counter and the sums and loads the configuration defaults.
`default_nettype none

module quad_motor_mixer_with_averager_top (
    input  var logic         clk,
    input  var logic         rst_n,
    input  var logic         s_axis_tvalid,
    output var logic         s_axis_tready,
    // thrust_cmd[15:0], roll_cmd[31:16], pitch_cmd[47:32], yaw_cmd[63:48]
    input  var logic [63:0]  s_axis_tdata,
    // bypass[0]
    input  var logic         s_axis_tuser,
    output var logic         m_axis_tvalid,
    input  var logic         m_axis_tready,
    // drive_1[15:0], drive_2[31:16], drive_3[47:32], drive_4[63:48],
    // avg_1[83:64], avg_2[103:84], avg_3[123:104], avg_4[143:124]
    output var logic [143:0] m_axis_tdata,
    // avg_ready[0]
    output var logic         m_axis_tuser,
    input  var logic         cfg_valid,
    output var logic         cfg_ready,
    input  var logic [2:0]   cfg_index,
    input  var logic [15:0]  cfg_data
);
    import qmm_pkg::*;

    cfg_t cfg_reg;

    // Input stage.
    logic a_valid_reg;
    cmd_t a_cmd_reg;
    logic a_ready;

    // Mix and accumulate stage.
    logic       b_valid_reg;
    drive_arr_t b_drive_reg;
    sum_arr_t   b_sum_reg;
    logic       b_avg_reg;
    logic       b_ready;
    logic       b_fire;

    // Output stage.
    logic       o_valid_reg;
    drive_arr_t o_drive_reg;
    avg_arr_t   o_avg_reg;
    avg_arr_t   o_avg_next;
    logic       o_flag_reg;
    logic       o_ready;

    // Accumulator state.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W:0]   count_inc;
    sum_arr_t         sums_reg;
    sum_arr_t         sums_next;
    drive_arr_t       drive;
    logic             window_done;
    logic             s_fire;
    logic             a_fire;

    logic [SUM_W+3:0]           scaled [4];
    logic [SUM_W+3+RECIP_W:0]   prod   [4];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_formation     <= 1'b1;
            cfg_reg.override_enable <= 1'b0;
            cfg_reg.override_m      <= '0;
            cfg_reg.idle_floor      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_X_FORMATION:     cfg_reg.x_formation     <= cfg_data[0];
                REG_OVERRIDE_ENABLE: cfg_reg.override_enable <= cfg_data[0];
                REG_OVERRIDE_M1:     cfg_reg.override_m[0]   <= cfg_data;
                REG_OVERRIDE_M2:     cfg_reg.override_m[1]   <= cfg_data;
                REG_OVERRIDE_M3:     cfg_reg.override_m[2]   <= cfg_data;
                REG_OVERRIDE_M4:     cfg_reg.override_m[3]   <= cfg_data;
                REG_IDLE_FLOOR:      cfg_reg.idle_floor      <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Backpressure chain through the three stages.
    assign o_ready       = !o_valid_reg || m_axis_tready;
    assign b_ready       = !b_valid_reg || o_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign a_fire        = a_valid_reg && b_ready;
    assign b_fire        = b_valid_reg && o_ready;

    // Input register; bypass words are dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= s_fire && !s_axis_tuser;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            a_cmd_reg <= s_axis_tdata;
    end

    qmm_mixer u_mixer (
        .cmd   (a_cmd_reg),
        .cfg   (cfg_reg),
        .drive (drive)
    );

    // Window count and running sums.
    always_comb
    begin
        count_inc   = {1'b0, count_reg} + 1'b1;
        window_done = (count_inc >= (CNT_W + 1)'(AVG_WINDOW));
        for (int i = 0; i < 4; i++)
            sums_next[i] = sums_reg[i] + SUM_W'(drive[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sums_reg  <= '0;
        end
        else if (a_fire)
        begin
            if (window_done)
            begin
                count_reg <= '0;
                sums_reg  <= '0;
            end
            else
            begin
                count_reg <= count_inc[CNT_W-1:0];
                sums_reg  <= sums_next;
            end
        end
    end

    // Mix and accumulate stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_drive_reg <= drive;
            b_sum_reg   <= sums_next;
            b_avg_reg   <= window_done;
        end
    end

    // Window mean: floor(sum * 16 / window) by reciprocal multiply.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            scaled[i] = {b_sum_reg[i], 4'b0000};
            prod[i]   = (SUM_W + 4 + RECIP_W)'(scaled[i]) *
                        (SUM_W + 4 + RECIP_W)'(DIV_RECIP);
            o_avg_next[i] = b_avg_reg ? prod[i][DIV_SHIFT+AVG_W-1:DIV_SHIFT] : '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            o_drive_reg <= b_drive_reg;
            o_avg_reg   <= o_avg_next;
            o_flag_reg  <= b_avg_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_avg_reg, o_drive_reg};
    assign m_axis_tuser  = o_flag_reg;

`ifndef SYNTH
    // The window counter never reaches the window length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(AVG_WINDOW))
        else $error("window counter out of range");

    // Closing a window clears all four sums.
    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && window_done) |=> (sums_reg == '0 && count_reg == '0))
        else $error("sums not cleared at window end");

    // A word that does not close the window advances the counter by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && !window_done) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("window counter did not advance");

    // Averages read as zero on words that do not close a window.
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[143:64] == '0))
        else $error("averages non-zero outside window end");
`endif

endmodule

`default_nettype wire

[bench/tb_quad_motor_mixer_with_averager_top.sv]
// Self-checking testbench for the quadrotor motor mixer with windowed drive averager.
`default_nettype none

module tb_quad_motor_mixer_with_averager_top;
    import qmm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // One expected result word, laid out as on m_axis.
    typedef struct packed {
        avg_arr_t   avg;
        logic       avg_ready;
        drive_arr_t drive;
    } mixer_result_t;

    // Predicts the drives and window means and checks each result word in order.
    class mixer_scoreboard;
        logic                 x_form;
        logic                 ovr_en;
        drive_arr_t           ovr_drive;
        logic [DRIVE_W-1:0]   floor_drive;
        int unsigned          window_fill;
        int unsigned          drive_sum [4];
        mixer_result_t        expected_q [$];
        int                   errors;
        int                   commands;
        int                   bypassed;
        int                   results;
        int                   windows;
        int                   reg_writes;

        function new();
            int i;
            x_form      = 1'b1;
            ovr_en      = 1'b0;
            ovr_drive   = '0;
            floor_drive = '0;
            window_fill = 0;
            for (i = 0; i < 4; i++)
                drive_sum[i] = 0;
            errors     = 0;
            commands   = 0;
            bypassed   = 0;
            results    = 0;
            windows    = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Only the low bits that fit a register are kept.
        function void apply_write(logic [2:0] idx, logic [15:0] data);
            reg_writes++;
            case (idx)
                REG_X_FORMATION:     x_form       = data[0];
                REG_OVERRIDE_ENABLE: ovr_en       = data[0];
                REG_OVERRIDE_M1:     ovr_drive[0] = data;
                REG_OVERRIDE_M2:     ovr_drive[1] = data;
                REG_OVERRIDE_M3:     ovr_drive[2] = data;
                REG_OVERRIDE_M4:     ovr_drive[3] = data;
                REG_IDLE_FLOOR:      floor_drive  = data;
                default: ;
            endcase
        endfunction

        function void note_command(logic [63:0] word, logic byp);
            int            t;
            int            r;
            int            p;
            int            y;
            int            mix [4];
            int            m;
            int            i;
            mixer_result_t res;
            commands++;
            // A bypassed word leaves the window untouched.
            if (byp)
            begin
                bypassed++;
                return;
            end
            t = int'(word[15:0]);
            r = int'($signed(word[31:16]));
            p = int'($signed(word[47:32]));
            y = int'($signed(word[63:48]));
            if (x_form)
            begin
                // Halving truncates toward zero.
                r = r / 2;
                p = p / 2;
                mix[0] = t - r + p + y;
                mix[1] = t - r - p - y;
                mix[2] = t + r - p + y;
                mix[3] = t + r + p - y;
            end
            else
            begin
                mix[0] = t + p + y;
                mix[1] = t - r - y;
                mix[2] = t - p + y;
                mix[3] = t + r - y;
            end
            res = '0;
            for (i = 0; i < 4; i++)
            begin
                if (ovr_en)
                    res.drive[i] = ovr_drive[i];
                else
                begin
                    m = mix[i];
                    if (m < 0)
                        m = 0;
                    else if (m > 65535)
                        m = 65535;
                    if (m < int'(floor_drive))
                        m = int'(floor_drive);
                    res.drive[i] = m[15:0];
                end
                drive_sum[i] = (drive_sum[i] + res.drive[i]) & 32'hFFFFF;
            end
            // The word that closes a window carries the means and clears the sums.
            window_fill++;
            if (window_fill >= AVG_WINDOW)
            begin
                res.avg_ready = 1'b1;
                windows++;
                for (i = 0; i < 4; i++)
                begin
                    res.avg[i]   = AVG_W'((drive_sum[i] * 16) / AVG_WINDOW);
                    drive_sum[i] = 0;
                end
                window_fill = 0;
            end
            expected_q.push_back(res);
        endfunction

        function void report(string field, int unsigned want, int unsigned got_val);
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %0h, got %0h", results, field, want, got_val);
        endfunction

        function void check_result(logic [143:0] word, logic avg_flag);
            mixer_result_t want;
            mixer_result_t got;
            int            i;
            results++;
            got.drive     = word[63:0];
            got.avg       = word[143:64];
            got.avg_ready = avg_flag;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: word %0h arrived with no command pending",
                             results, word);
                return;
            end
            want = expected_q.pop_front();
            for (i = 0; i < 4; i++)
                if (got.drive[i] !== want.drive[i])
                    report($sformatf("drive_%0d", i + 1), want.drive[i], got.drive[i]);
            if (got.avg_ready !== want.avg_ready)
                report("avg_ready", want.avg_ready, got.avg_ready);
            for (i = 0; i < 4; i++)
                if (got.avg[i] !== want.avg[i])
                    report($sformatf("avg_%0d", i + 1), want.avg[i], got.avg[i]);
        endfunction
    endclass

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid     = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index     = '0;
    logic [15:0]  cfg_data      = '0;

    mixer_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int unsigned     cycle_count    = 0;

    quad_motor_mixer_with_averager_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a period of ten units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is ended if it goes on far longer than any correct run could.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, sb.pending());
            $display("[quad_motor_mixer_with_averager_top] ERROR");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idling phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Every accepted word on each channel is handed to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.apply_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Offers one command word after a random gap and returns once it is taken.
    task automatic send_command(input logic [15:0] thrust, input logic [15:0] roll,
                                input logic [15:0] pitch, input logic [15:0] yaw,
                                input logic byp);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, pitch, roll, thrust};
        s_axis_tuser  <= byp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds the write channel valid until the word is taken.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the pipe settle.
    task automatic wait_idle(input int settle);
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Stops the command stream, waits for the block to go idle and writes every register.
    task automatic load_config(input logic [15:0] x_word, input logic [15:0] ovr_word,
                               input logic [15:0] m1, input logic [15:0] m2,
                               input logic [15:0] m3, input logic [15:0] m4,
                               input logic [15:0] floor_word);
        s_axis_tvalid <= 1'b0;
        wait_idle(4);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_X_FORMATION, x_word);
        write_reg(REG_OVERRIDE_ENABLE, ovr_word);
        write_reg(REG_OVERRIDE_M1, m1);
        write_reg(REG_OVERRIDE_M2, m2);
        write_reg(REG_OVERRIDE_M3, m3);
        write_reg(REG_OVERRIDE_M4, m4);
        write_reg(REG_IDLE_FLOOR, floor_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
            3:       begin send_idle_pct = 11; recv_stall_pct = 11; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Mostly full-range values, with the extremes and small values near zero mixed in.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0:       w = 16'h0000;
                    1:       w = 16'hFFFF;
                    2:       w = 16'h7FFF;
                    default: w = 16'h8000;
                endcase
            end
            1:       w = 16'($urandom_range(511)) - 16'd256;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    initial
    begin
        int   phase;
        int   sent;
        logic byp;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings: X mixing, no override, no floor.
        set_idling(0);
        send_command(16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_command(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_command(16'd0, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_command(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        // Minus one halves to zero; odd values truncate toward zero.
        send_command(16'd1000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_command(16'd1000, 16'h0001, 16'hFFFD, 16'h0005, 1'b0);
        send_command(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_command(16'd32768, 16'd100, 16'hFF38, 16'd300, 1'b0);
        send_command(16'd40000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_command(16'd20000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_command(16'd30000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0);

        // Plus mixing selected by a word with upper bits set, and an idle floor.
        load_config(16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd5000);
        send_command(16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_command(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_command(16'd10000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_command(16'd3000, 16'h0100, 16'hFF00, 16'h0010, 1'b0);

        // Override drives the fixed values, bypassing both clamp and floor.
        load_config(16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 16'hA5A5, 16'hFFFF);
        send_command(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_command(16'd0, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_command(16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);

        // The highest floor lifts every drive to full scale.
        load_config(16'h0001, 16'h0000, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'hFFFF);
        send_command(16'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_command(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);

        // Random words across several register settings and every idling pattern.
        for (phase = 0; phase < 8; phase++)
        begin
            set_idling(phase % 4);
            load_config((phase == 0) ? 16'h0001 : (phase == 2) ? 16'h0000 : 16'($urandom),
                        {15'($urandom), (phase == 3 || phase == 6)},
                        (phase == 3) ? 16'hFFFF : 16'($urandom),
                        (phase == 3) ? 16'h0000 : 16'($urandom),
                        (phase == 3) ? 16'hFFFF : 16'($urandom),
                        (phase == 3) ? 16'h0000 : 16'($urandom),
                        (phase == 1) ? 16'hFFFF :
                        (phase == 0 || phase == 4) ? 16'h0000 :
                        16'($urandom_range(4000)));
            sent = 0;
            while (sent < 50)
            begin
                byp = ($urandom_range(9) == 0);
                send_command(pick_word(), pick_word(), pick_word(), pick_word(), byp);
                if (!byp)
                    sent++;
            end
        end

        // Drain and watch a little longer for stray results.
        s_axis_tvalid <= 1'b0;
        set_idling(0);
        wait_idle(8);

        $display("Covered %0d command words (%0d bypassed), %0d results, %0d closed windows,",
                 sb.commands, sb.bypassed, sb.results, sb.windows);
        $display("%0d register writes and %0d mismatches.", sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[quad_motor_mixer_with_averager_top] OK");
        else
            $display("[quad_motor_mixer_with_averager_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
